### rtl/sird_pkg.sv
package sird_pkg;

	localparam int DEF_MAX_RADIX   = 16;
	localparam int DEF_NUMBER_BITS = 32;

	localparam int SYMBOL_COUNT = 16;
	localparam int SYM_W        = 8;
	localparam int DIGIT_W      = 4;
	localparam int SIZE_W       = 5;
	localparam int CFG_W        = 64;
	localparam int CFG_INDEX_W  = 2;
	localparam int TABLE_W      = SYMBOL_COUNT * SYM_W;

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'd43;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'd45;
	localparam logic [SYM_W-1:0] SYM_NONE  = 8'd0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_SIZE    = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} state_t;

	function automatic logic [SYM_W-1:0] symbol_at(input logic [TABLE_W-1:0] syms,
			input logic [DIGIT_W-1:0] d);
		return syms[{d, 3'b000} +: SYM_W];
	endfunction

	// The base is usable only if its size is in range and the symbols in use are
	// distinct and contain neither sign character.
	function automatic logic base_ok(input logic [SIZE_W-1:0] size,
			input logic [TABLE_W-1:0] syms, input int max_radix);
		logic ok;
		logic [SYM_W-1:0] si;
		ok = (size >= SIZE_W'(2)) && (32'(size) <= 32'(max_radix));
		for (int i = 0; i < SYMBOL_COUNT; i++) begin
			si = syms[i*SYM_W +: SYM_W];
			if (SIZE_W'(i) < size) begin
				if (si == SYM_PLUS || si == SYM_MINUS) begin
					ok = 1'b0;
				end
				for (int j = 0; j < SYMBOL_COUNT; j++) begin
					if (j > i && SIZE_W'(j) < size && syms[j*SYM_W +: SYM_W] == si) begin
						ok = 1'b0;
					end
				end
			end
		end
		return ok;
	endfunction

endpackage

### rtl/sird_div.sv
module sird_div
	import sird_pkg::*;
#(
	parameter int NUMBER_BITS = DEF_NUMBER_BITS,
	parameter int RADIX_W     = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [NUMBER_BITS-1:0] dividend,
	input  logic [RADIX_W-1:0]     divisor,
	output logic                   done,
	output logic [NUMBER_BITS-1:0] quotient,
	output logic [RADIX_W-1:0]     remainder
);

	localparam int BIT_CNT_W = $clog2(NUMBER_BITS);

	logic                   run_q;
	logic                   done_q;
	logic [BIT_CNT_W-1:0]   cnt_q;
	logic [NUMBER_BITS-1:0] acc_q;
	logic [RADIX_W-1:0]     rem_q;

	logic [RADIX_W:0] trial;
	logic [RADIX_W:0] diff;
	logic             ge;

	// Restoring division, one quotient bit per cycle. Quotient bits shift into
	// the bottom of the dividend register as its top bits move into the remainder.
	always_comb begin
		trial = {rem_q, acc_q[NUMBER_BITS-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + BIT_CNT_W'(1);
				if (cnt_q == BIT_CNT_W'(NUMBER_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			acc_q <= {acc_q[NUMBER_BITS-2:0], ge};
			rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

### rtl/sird_stack.sv
module sird_stack
	import sird_pkg::*;
#(
	parameter int DEPTH = DEF_NUMBER_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DIGIT_W-1:0]       wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DIGIT_W-1:0]       rdata
);

	logic [DIGIT_W-1:0] mem_q [DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/signed_integer_to_radix_digits_top.sv
// Converts a signed number into characters of a configurable base of up to sixteen
// symbols. The base is checked in the cycle after start; an unusable base gives a
// single result with base_invalid set. Otherwise a minus sign comes first for a
// negative number, then the digits, most significant first, the final one with
// last set. Each digit comes from the bit-serial divider, which yields one
// quotient bit per cycle, and is then written to the digit stack and read back out
// of it in reverse order. The final result reaches the ports only as busy falls or
// after it, so the next item may already be under way. The digits come out on
// consecutive cycles, after an idle gap that follows the minus sign, with strobe
// high for one cycle each; the receiver must take every transfer as it comes, and
// there is no way to hold results off.
module signed_integer_to_radix_digits_top
	import sird_pkg::*;
#(
	parameter int MAX_RADIX   = DEF_MAX_RADIX,
	parameter int NUMBER_BITS = DEF_NUMBER_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   strobe,
	output logic [SYM_W-1:0]       character,
	output logic                   base_invalid,
	output logic                   last
);

	localparam int RADIX_W = $clog2(MAX_RADIX + 1);
	localparam int CNT_W   = $clog2(NUMBER_BITS + 1);
	localparam int ADDR_W  = $clog2(NUMBER_BITS);

	logic [SIZE_W-1:0]      base_size_q;
	logic [TABLE_W-1:0]     symbols_q;

	state_t                 state_q;
	state_t                 state_n;
	logic [NUMBER_BITS-1:0] num_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pend_s1;
	logic                   pend_last_s1;
	logic                   strobe_q;
	logic [SYM_W-1:0]       char_q;
	logic                   inv_q;
	logic                   last_q;

	logic                   neg;
	logic [NUMBER_BITS-1:0] magnitude;
	logic                   base_valid;
	logic                   more;

	logic                   div_go;
	logic                   div_first;
	logic                   div_done;
	logic [NUMBER_BITS-1:0] div_dividend;
	logic [NUMBER_BITS-1:0] div_quot;
	logic [RADIX_W-1:0]     div_rem;

	logic                   stack_we;
	logic                   stack_re;
	logic [DIGIT_W-1:0]     stack_rdata;
	logic [CNT_W-1:0]       rd_index;

	logic                   emit_invalid;
	logic                   emit_sign;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q <= '0;
			symbols_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_SIZE:    base_size_q <= cfg_data[SIZE_W-1:0];
				REG_SYMBOLS_LOW:  symbols_q[CFG_W-1:0] <= cfg_data;
				REG_SYMBOLS_HIGH: symbols_q[TABLE_W-1:CFG_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The magnitude is taken unsigned, so the most negative number keeps its full value.
	assign neg          = num_q[NUMBER_BITS-1];
	assign magnitude    = neg ? (~num_q + NUMBER_BITS'(1)) : num_q;
	assign base_valid   = base_ok(base_size_q, symbols_q, MAX_RADIX);
	assign more         = (div_quot != '0) && (count_q < CNT_W'(NUMBER_BITS - 1));
	assign div_dividend = div_first ? magnitude : div_quot;
	assign rd_index     = count_q - CNT_W'(1);

	always_comb begin
		state_n      = state_q;
		div_go       = 1'b0;
		div_first    = 1'b0;
		stack_we     = 1'b0;
		stack_re     = 1'b0;
		emit_invalid = 1'b0;
		emit_sign    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!base_valid) begin
					emit_invalid = 1'b1;
					state_n      = ST_IDLE;
				end else begin
					div_go    = 1'b1;
					div_first = 1'b1;
					state_n   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					stack_we = 1'b1;
					if (more) begin
						div_go = 1'b1;
					end else begin
						state_n = neg ? ST_SIGN : ST_EMIT;
					end
				end
			end
			ST_SIGN: begin
				emit_sign = 1'b1;
				state_n   = ST_EMIT;
			end
			ST_EMIT: begin
				stack_re = 1'b1;
				if (count_q == CNT_W'(1)) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			pend_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			pend_s1  <= stack_re;
			strobe_q <= emit_invalid | emit_sign | pend_s1;
			if (state_q == ST_CHECK) begin
				count_q <= '0;
			end else if (stack_we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (stack_re) begin
				count_q <= rd_index;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			num_q <= number;
		end
		if (state_q == ST_CHECK) begin
			radix_q <= RADIX_W'(base_size_q);
		end
		pend_last_s1 <= (count_q == CNT_W'(1));
		inv_q        <= emit_invalid;
		last_q       <= emit_invalid | (pend_s1 & pend_last_s1);
		priority if (emit_invalid) begin
			char_q <= SYM_NONE;
		end else if (emit_sign) begin
			char_q <= SYM_MINUS;
		end else begin
			char_q <= symbol_at(symbols_q, stack_rdata);
		end
	end

	sird_div #(
		.NUMBER_BITS(NUMBER_BITS),
		.RADIX_W    (RADIX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_first ? RADIX_W'(base_size_q) : radix_q),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	sird_stack #(
		.DEPTH(NUMBER_BITS)
	) u_stack (
		.clk  (clk),
		.we   (stack_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(DIGIT_W'(div_rem)),
		.re   (stack_re),
		.raddr(rd_index[ADDR_W-1:0]),
		.rdata(stack_rdata)
	);

	// The last digit read may still be on its way out while a new item is taken.
	assign busy         = (state_q != ST_IDLE);
	assign strobe       = strobe_q;
	assign character    = char_q;
	assign base_invalid = inv_q;
	assign last         = last_q;

endmodule
